// File: hdl/dgwe_pkg.sv
package dgwe_pkg;
  localparam int NUM_VERTICES = 16;
  localparam int LIST_DEPTH = 256;
  localparam int VW = 4;
  localparam int NVX = (NUM_VERTICES < 16) ? NUM_VERTICES : 16;
  localparam int LAW = $clog2(LIST_DEPTH);
  localparam int LCW = $clog2(LIST_DEPTH + 1);

  localparam logic [2:0] FN_ADD_V = 3'd0;
  localparam logic [2:0] FN_ADD_E = 3'd1;
  localparam logic [2:0] FN_DEL_E = 3'd2;
  localparam logic [2:0] FN_BFS = 3'd3;
  localparam logic [2:0] FN_DFS = 3'd4;
  localparam logic [2:0] FN_CYC = 3'd5;
  localparam logic [2:0] FN_DAG = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_POP, S_RD, S_CHK, S_SCAN, S_WALKEND, S_DAGNEXT, S_ANSWER
  } state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic pop;
    logic chk;
    logic scan_step;
    logic dag_next;
    logic emit_walk;
    logic emit_ans;
    logic upd_graph;
  } cmd_t;

  typedef struct packed {
    logic is_walk;
    logic is_cyc;
    logic is_dag;
    logic is_upd;
    logic src_ok;
    logic list_empty;
    logic was_visited;
    logic scan_done;
    logic scan_stop;
    logic hit_cycle;
    logic dag_more;
  } stat_t;
endpackage

// File: hdl/dgwe_ram.sv
module dgwe_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/dgwe_ctrl.sv
module dgwe_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  dgwe_pkg::stat_t st,
  output dgwe_pkg::cmd_t  cmd
);
  import dgwe_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_INIT;
      S_INIT: begin
        priority if (st.is_upd) state_nxt = S_IDLE;
        else if (st.is_dag) state_nxt = st.dag_more ? S_POP : S_ANSWER;
        else if (st.is_walk) state_nxt = st.src_ok ? S_POP : S_IDLE;
        else if (st.is_cyc) state_nxt = st.src_ok ? S_POP : S_ANSWER;
        else state_nxt = S_IDLE;
      end
      S_POP: begin
        priority if (st.list_empty)
          state_nxt = st.is_walk ? S_WALKEND : (st.is_dag ? S_DAGNEXT : S_ANSWER);
        else state_nxt = S_RD;
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: state_nxt = st.was_visited ? S_POP : S_SCAN;
      S_SCAN: begin
        priority if (st.hit_cycle) state_nxt = S_ANSWER;
        else if (st.scan_stop) state_nxt = S_WALKEND;
        else if (st.scan_done) state_nxt = S_POP;
      end
      S_WALKEND: state_nxt = S_IDLE;
      S_DAGNEXT: state_nxt = st.dag_more ? S_POP : S_ANSWER;
      S_ANSWER: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: cmd.load = start;
      S_INIT: begin
        cmd.upd_graph = st.is_upd;
        cmd.init = 1'b1;
      end
      S_POP: ;
      // The list pointer moves only once the read address has been held through S_POP and S_RD.
      S_RD: cmd.pop = 1'b1;
      S_CHK: cmd.chk = 1'b1;
      S_SCAN: cmd.scan_step = 1'b1;
      S_WALKEND: cmd.emit_walk = 1'b1;
      S_DAGNEXT: cmd.dag_next = 1'b1;
      S_ANSWER: cmd.emit_ans = 1'b1;
      default: ;
    endcase
  end
endmodule

// File: hdl/dgwe_dp.sv
module dgwe_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [2:0]              in_func,
  input  logic [dgwe_pkg::VW-1:0] in_vertex_a,
  input  logic [dgwe_pkg::VW-1:0] in_vertex_b,
  input  logic                    in_use_dest,
  input  dgwe_pkg::cmd_t           cmd,
  output dgwe_pkg::stat_t          st,
  output logic                    out_valid,
  output logic [dgwe_pkg::VW-1:0] out_visited_vertex,
  output logic                    out_answer,
  output logic                    out_last
);
  import dgwe_pkg::*;

  logic [15:0] adj_r [16];
  logic [15:0] present_r, visited_r;
  logic [2:0] func_r;
  logic [VW-1:0] a_r, b_r, src_r, u_r, w_r;
  logic use_r;
  logic [LCW-1:0] head_r, tail_r;
  logic pend_r;            // a walk beat is held to learn whether it is the last one
  logic [VW-1:0] pend_v_r;
  logic ov_r, oa_r, ol_r;
  logic [VW-1:0] ovv_r;
  logic dag_hit_r;
  logic [VW:0] dag_v_r;

  logic a_ok, b_ok, dfs;
  logic we;
  logic [LAW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, rdata;
  logic push_ok;
  logic [VW:0] dag_find;
  logic dag_reseed;
  logic emit_mid;
  logic wbit;

  assign a_ok = ({1'b0, a_r} < (VW+1)'(NVX));
  assign b_ok = ({1'b0, b_r} < (VW+1)'(NVX));
  assign dfs = (func_r != FN_BFS);
  assign push_ok = (tail_r < LCW'(LIST_DEPTH));
  assign wbit = adj_r[u_r][w_r];

  dgwe_ram #(.WIDTH(VW), .DEPTH(LIST_DEPTH)) u_list (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    dag_find = (VW+1)'(NVX);
    for (int i = NVX - 1; i >= 0; i--) begin
      if (present_r[i] && ((VW+1)'(i) >= dag_v_r)) dag_find = (VW+1)'(i);
    end
  end

  assign dag_reseed = cmd.dag_next && (dag_find != (VW+1)'(NVX));
  // A newly visited vertex during a walk releases the beat held for the previous one.
  assign emit_mid = cmd.chk && !visited_r[rdata] && st.is_walk && pend_r;

  always_comb begin
    we = 1'b0;
    waddr = tail_r[LAW-1:0];
    wdata = w_r;
    if (cmd.init || dag_reseed) begin
      we = 1'b1;
      waddr = '0;
      wdata = (func_r == FN_DAG) ? dag_find[VW-1:0] : a_r;
    end else if (cmd.scan_step && wbit && !visited_r[w_r] && push_ok) begin
      we = 1'b1;
    end
    raddr = dfs ? LAW'(tail_r - 1'b1) : head_r[LAW-1:0];
  end

  always_comb begin
    st.is_walk = (func_r == FN_BFS) || (func_r == FN_DFS);
    st.is_cyc = (func_r == FN_CYC);
    st.is_dag = (func_r == FN_DAG);
    st.is_upd = (func_r == FN_ADD_V) || (func_r == FN_ADD_E) || (func_r == FN_DEL_E);
    st.src_ok = a_ok;
    st.list_empty = (head_r == tail_r);
    st.was_visited = visited_r[rdata];
    st.scan_done = ({1'b0, w_r} == (VW+1)'(NVX - 1));
    st.scan_stop = st.is_walk && wbit && use_r && b_ok && (w_r == b_r);
    st.hit_cycle = !st.is_walk && wbit && adj_r[w_r][src_r];
    st.dag_more = (func_r == FN_DAG) && (dag_find != (VW+1)'(NVX));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) adj_r[i] <= '0;
      present_r <= '0;
      visited_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      func_r <= FN_ADD_V;
      pend_r <= 1'b0;
      ov_r <= 1'b0;
      dag_hit_r <= 1'b0;
      dag_v_r <= '0;
    end else begin
      ov_r <= emit_mid || (cmd.emit_walk && pend_r) || cmd.emit_ans;
      if (cmd.load) begin
        func_r <= in_func;
        a_r <= in_vertex_a;
        b_r <= in_vertex_b;
        use_r <= in_use_dest;
        dag_v_r <= '0;
        dag_hit_r <= 1'b0;
      end
      if (cmd.upd_graph && a_ok) begin
        if (func_r == FN_ADD_V) present_r[a_r] <= 1'b1;
        else if (b_ok) adj_r[a_r][b_r] <= (func_r == FN_ADD_E);
      end
      if (cmd.init || dag_reseed) begin
        visited_r <= '0;
        head_r <= '0;
        tail_r <= LCW'(1);
        src_r <= (func_r == FN_DAG) ? dag_find[VW-1:0] : a_r;
        dag_v_r <= dag_find + 1'b1;
        pend_r <= 1'b0;
      end
      if (cmd.pop) begin
        if (dfs) tail_r <= tail_r - 1'b1;
        else head_r <= head_r + 1'b1;
      end
      if (cmd.chk) begin
        u_r <= rdata;
        w_r <= '0;
        if (!visited_r[rdata]) begin
          visited_r[rdata] <= 1'b1;
          if (st.is_walk) begin
            if (pend_r) begin
              ovv_r <= pend_v_r; oa_r <= 1'b0; ol_r <= 1'b0;
            end
            pend_r <= 1'b1;
            pend_v_r <= rdata;
          end
        end
      end
      if (cmd.scan_step) begin
        if (wbit && !visited_r[w_r] && push_ok) tail_r <= tail_r + 1'b1;
        w_r <= w_r + 1'b1;
        if (st.hit_cycle) dag_hit_r <= 1'b1;
      end
      if (cmd.emit_walk && pend_r) begin
        ovv_r <= pend_v_r; oa_r <= 1'b0; ol_r <= 1'b1;
        pend_r <= 1'b0;
      end
      if (cmd.emit_ans) begin
        ovv_r <= '0; ol_r <= 1'b1;
        oa_r <= (func_r == FN_DAG) ? !dag_hit_r : dag_hit_r;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_visited_vertex = ovv_r;
  assign out_answer = oa_r;
  assign out_last = ol_r;
endmodule

// File: hdl/directed_graph_walk_engine.sv
// An edit holds busy only in S_INIT; a walk passes S_POP, S_RD and S_CHK per pop,
// then scans the vertices in order as successors in S_SCAN for each newly visited vertex.
// The DAG test repeats that search from every present vertex until it finds a cycle.
// One command runs at a time; busy falls in the cycle that carries the last beat.
// Results are one-cycle strobed beats that the receiver cannot stall.
// Reset (synchronous, active low) clears the graph, the walk state and the FSM.
module directed_graph_walk_engine (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              in_func,
  input  logic [dgwe_pkg::VW-1:0] in_vertex_a,
  input  logic [dgwe_pkg::VW-1:0] in_vertex_b,
  input  logic                    in_use_dest,
  output logic                    out_valid,
  output logic [dgwe_pkg::VW-1:0] out_visited_vertex,
  output logic                    out_answer,
  output logic                    out_last
);
  import dgwe_pkg::*;
  cmd_t cmd;
  stat_t st;

  dgwe_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .st(st), .cmd(cmd));

  dgwe_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_func(in_func), .in_vertex_a(in_vertex_a),
    .in_vertex_b(in_vertex_b), .in_use_dest(in_use_dest), .cmd(cmd), .st(st),
    .out_valid(out_valid), .out_visited_vertex(out_visited_vertex),
    .out_answer(out_answer), .out_last(out_last)
  );
endmodule

// File: bench/directed_graph_walk_engine_test.sv
module directed_graph_walk_engine_test;
  import dgwe_pkg::*;

  typedef struct packed {
    logic [3:0] vtx;
    logic       answer;
    logic       last;
  } beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] in_func = '0;
  logic [3:0] in_vertex_a = '0;
  logic [3:0] in_vertex_b = '0;
  logic       in_use_dest = 1'b0;
  logic       out_valid;
  logic [3:0] out_visited_vertex;
  logic       out_answer;
  logic       out_last;

  directed_graph_walk_engine dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .in_use_dest(in_use_dest), .out_valid(out_valid),
    .out_visited_vertex(out_visited_vertex), .out_answer(out_answer),
    .out_last(out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Graph mirror kept in step with every accepted command.
  logic [15:0] graph_adj [16];
  logic [15:0] graph_present;
  beat_t       expected_beats [$];
  int          errors = 0;
  int          cmds_sent = 0;
  int          beats_seen = 0;
  int          idle_cycles = 0;
  logic        accepted_now = 1'b0;

  task automatic walk_graph(input int src, input bit dfs, input int dest,
                            input bit cyc, output bit hit);
    logic [3:0]  wl [256];
    int          head, tail, n, u;
    logic [15:0] vis;
    bit          stop;
    beat_t       b;
    head = 0; tail = 1; n = 0; vis = '0; stop = 0; hit = 0;
    wl[0] = src[3:0];
    while (head != tail && !stop) begin
      if (dfs) begin
        tail--;
        u = wl[tail];
      end else begin
        u = wl[head];
        head++;
      end
      if (vis[u]) continue;
      vis[u] = 1'b1;
      if (!cyc && n < 16) begin
        b.vtx = u[3:0]; b.answer = 1'b0; b.last = 1'b0;
        expected_beats.push_back(b);
        n++;
      end
      for (int w = 0; w < 16; w++) begin
        if (!graph_adj[u][w]) continue;
        if (!vis[w] && tail < 256) begin
          wl[tail] = w[3:0];
          tail++;
        end
        if (cyc) begin
          if (graph_adj[w][src]) begin
            hit = 1;
            return;
          end
        end else if (dest == w) begin
          stop = 1;
          break;
        end
      end
    end
    if (!cyc && n > 0) expected_beats[expected_beats.size()-1].last = 1'b1;
  endtask

  task automatic predict_command(input logic [2:0] f, input logic [3:0] a,
                                 input logic [3:0] b, input logic use_d);
    bit    hit;
    beat_t r;
    r.vtx = '0; r.last = 1'b1; r.answer = 1'b0;
    case (f)
      FN_ADD_V: graph_present[a] = 1'b1;
      FN_ADD_E: graph_adj[a][b] = 1'b1;
      FN_DEL_E: graph_adj[a][b] = 1'b0;
      FN_BFS, FN_DFS:
        walk_graph(a, f == FN_DFS, use_d ? int'(b) : -1, 0, hit);
      FN_CYC: begin
        walk_graph(a, 1, -1, 1, hit);
        r.answer = hit;
        expected_beats.push_back(r);
      end
      FN_DAG: begin
        r.answer = 1'b1;
        for (int v = 0; v < 16; v++) begin
          if (graph_present[v]) begin
            walk_graph(v, 1, -1, 1, hit);
            if (hit) begin
              r.answer = 1'b0;
              break;
            end
          end
        end
        expected_beats.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic send_command(input logic [2:0] f, input logic [3:0] a,
                              input logic [3:0] b, input logic use_d);
    int gap;
    gap = $urandom_range(0, 17);
    repeat (gap) @(negedge clk);
    start = 1'b1;
    in_func = f; in_vertex_a = a; in_vertex_b = b; in_use_dest = use_d;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_command(f, a, b, use_d);
    cmds_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_beats.size() != 0) @(negedge clk);
  endtask

  // Result checker: strobed beats cannot be held off, so sample each one.
  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_valid) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat vtx=%0d answer=%0d last=%0d", $time,
                 out_visited_vertex, out_answer, out_last);
        errors++;
      end else begin
        e = expected_beats.pop_front();
        if (out_visited_vertex !== e.vtx) begin
          $display("%0t: visited_vertex expected %0d actual %0d", $time, e.vtx,
                   out_visited_vertex);
          errors++;
        end
        if (out_answer !== e.answer) begin
          $display("%0t: answer expected %0d actual %0d", $time, e.answer,
                   out_answer);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t: last expected %0d actual %0d", $time, e.last, out_last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles where no command is taken and no beat arrives.
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 60000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_edits_and_walks();
    send_command(FN_ADD_V, 4'd0, 4'd0, 1'b0);
    send_command(FN_ADD_V, 4'd15, 4'd0, 1'b0);
    send_command(FN_ADD_E, 4'd0, 4'd15, 1'b0);
    send_command(FN_ADD_E, 4'd0, 4'd3, 1'b0);
    send_command(FN_ADD_E, 4'd3, 4'd15, 1'b0);
    send_command(FN_BFS, 4'd0, 4'd0, 1'b0);
    send_command(FN_DFS, 4'd0, 4'd0, 1'b0);
    send_command(FN_BFS, 4'd0, 4'd15, 1'b1);
    send_command(FN_DFS, 4'd0, 4'd0, 1'b1);   // destination is the source
    send_command(FN_BFS, 4'd9, 4'd0, 1'b0);   // lone vertex with no edges
    send_command(3'd7, 4'd15, 4'd15, 1'b1);   // unused code is ignored
  endtask

  task automatic test_cycles_and_dag();
    send_command(FN_DAG, 4'd0, 4'd0, 1'b0);
    send_command(FN_CYC, 4'd0, 4'd0, 1'b0);
    send_command(FN_ADD_E, 4'd15, 4'd0, 1'b0);
    send_command(FN_CYC, 4'd0, 4'd0, 1'b0);
    send_command(FN_DAG, 4'd0, 4'd0, 1'b0);
    send_command(FN_DEL_E, 4'd15, 4'd0, 1'b0);
    send_command(FN_ADD_E, 4'd7, 4'd7, 1'b0); // self loop stops a walk at once
    send_command(FN_DFS, 4'd7, 4'd7, 1'b1);
    send_command(FN_CYC, 4'd7, 4'd0, 1'b0);
    send_command(FN_DEL_E, 4'd7, 4'd7, 1'b0);
    wait_drained();
  endtask

  task automatic test_full_list();
    // A complete graph with self loops on eight vertices keeps the work list deep.
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++)
        send_command(FN_ADD_E, i[3:0], j[3:0], 1'b0);
    send_command(FN_BFS, 4'd5, 4'd0, 1'b0);
    send_command(FN_DFS, 4'd7, 4'd0, 1'b0);
    send_command(FN_DAG, 4'd0, 4'd0, 1'b0);
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++)
        if ($urandom_range(0, 3) != 0) send_command(FN_DEL_E, i[3:0], j[3:0], 1'b0);
  endtask

  task automatic test_random_mix();
    int          density, pick;
    logic [2:0]  f;
    for (int n = 0; n < 350; n++) begin
      if (n % 100 == 0) density = $urandom_range(10, 90);
      pick = $urandom_range(0, 99);
      if (pick < 45) f = ($urandom_range(0, 99) < density) ? FN_ADD_E : FN_DEL_E;
      else if (pick < 50) f = FN_ADD_V;
      else if (pick < 68) f = FN_BFS;
      else if (pick < 86) f = FN_DFS;
      else if (pick < 93) f = FN_CYC;
      else if (pick < 98) f = FN_DAG;
      else f = 3'd7;
      send_command(f, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)));
      if (n == 175) wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) graph_adj[i] = '0;
    graph_present = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_edits_and_walks();
    test_cycles_and_dag();
    test_full_list();
    test_random_mix();
    wait_drained();
    repeat (400) @(posedge clk);
    $display("Covered %0d commands (edits, walks with and without a stop vertex,", cmds_sent);
    $display("cycle and acyclic tests, dense graphs) and checked %0d beats.", beats_seen);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
hdl/dgwe_pkg.sv
hdl/dgwe_ram.sv
hdl/dgwe_ctrl.sv
hdl/dgwe_dp.sv
hdl/directed_graph_walk_engine.sv
bench/directed_graph_walk_engine_test.sv
